// ===== design/pett_pkg.sv =====
// Package for the periodic timer table: command and status codes, FSM states,
// the per-slot entry record and the saturating add.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pett_pkg;

    localparam int TIME_W = 32;
    localparam int HID_W  = 8;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    typedef enum logic [1:0] {
        CMD_ADD     = 2'd0,
        CMD_RUN     = 2'd1,
        CMD_SETBACK = 2'd2,
        CMD_NOP     = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_ADDED   = 3'd0,
        ST_FULL    = 3'd1,
        ST_FIRED   = 3'd2,
        ST_NONE    = 3'd3,
        ST_SETBACK = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT,
        S_SINGLE
    } state_t;

    typedef struct packed {
        logic [TIME_W-1:0] due;
        logic [TIME_W-1:0] ival;
        logic [HID_W-1:0]  hid;
        logic              fired;
    } entry_t;

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== design/pett_if.sv =====
// Handshake interfaces for the timer table: command channel and result channel.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface pett_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [31:0] time_now;
    logic [31:0] period;
    logic [7:0]  handler_id;
    logic [31:0] shift_by;
    modport source (output valid, command, time_now, period, handler_id, shift_by,
                    input ready);
    modport sink   (input valid, command, time_now, period, handler_id, shift_by,
                    output ready);
endinterface

interface pett_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [4:0]  slot;
    logic [7:0]  fired_handler;
    logic [31:0] next_due;
    logic        last;
    modport source (output valid, status, slot, fired_handler, next_due, last,
                    input ready);
    modport sink   (input valid, status, slot, fired_handler, next_due, last,
                     output ready);
endinterface
`default_nettype wire

// ===== design/pett_cell.sv =====
// One storage cell of the rotating timer chain; passes its entry to the
// neighbor on every shift. Depends on pett_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pett_cell (
    input  wire logic            clk,
    input  wire logic            shift_en,
    input  wire pett_pkg::entry_t d,
    output pett_pkg::entry_t     q
);
    import pett_pkg::*;

    entry_t entry_reg;

    // take the neighbor's entry on shift
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            entry_reg <= d;
        end
    end

    assign q = entry_reg;
endmodule
`default_nettype wire

// ===== design/pett_head.sv =====
// Update unit at the head of the chain: applies add, run and set back to the
// entry leaving cell 0. Depends on pett_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pett_head #(
    parameter int IDX_W = 5,
    parameter int CNT_W = 6
) (
    input  wire logic                     scan,
    input  wire pett_pkg::cmd_t           cmd,
    input  wire logic [31:0]              now,
    input  wire logic [31:0]              per,
    input  wire logic [7:0]               hid,
    input  wire logic [31:0]              by,
    input  wire logic                     room,
    input  wire logic [IDX_W-1:0]         idx,
    input  wire logic [CNT_W-1:0]         count,
    input  wire pett_pkg::entry_t         d,
    output pett_pkg::entry_t              q,
    output logic                          fire,
    output logic                          keep
);
    import pett_pkg::*;

    logic active;
    logic at_free;

    assign active  = CNT_W'(idx) < count;
    assign at_free = CNT_W'(idx) == count;

    // update the head entry for the current command
    always_comb
    begin
        q       = d;
        q.fired = 1'b0;
        fire    = 1'b0;
        keep    = active;
        if (scan)
        begin
            case (cmd)
                CMD_ADD:
                begin
                    if (at_free && room)
                    begin
                        q.due  = sat_add(now, per);
                        q.ival = per;
                        q.hid  = hid;
                        keep   = 1'b1;
                    end
                end
                CMD_RUN:
                begin
                    if (active && (d.due <= now))
                    begin
                        q.fired = 1'b1;
                        q.due   = sat_add(now, d.ival);
                        fire    = 1'b1;
                    end
                end
                CMD_SETBACK:
                begin
                    if (active)
                    begin
                        q.due = (d.due > by) ? d.due - by : '0;
                    end
                end
                default:
                begin
                    q.fired = 1'b0;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== design/periodic_event_timer_table_core.sv =====
// Top level of the periodic timer table: rotating chain of slot cells, head
// update unit, control FSM and result register. Depends on pett_pkg, pett_if,
// pett_cell and pett_head.
//
//  channel  dir  payload                                          transaction
//  cmd_ch   in   command, time_now, period, handler_id, shift_by  valid & ready
//  res_ch   out  status, slot, fired_handler, next_due, last      valid & ready
//
// A command other than a no-op is accepted in idle, then rotates the whole
// chain once, updating the entry at the head and tracking the earliest due
// time. An add, a set back or a run with nothing due then loads its result
// in the single-result state before the table returns to idle.
// A run that fires entries rotates a second time to deliver them, one per
// cycle while the result channel takes them, then returns to idle.
// A stalled result holds the delivery pass at a fired entry and holds the
// result-load cycle; the scan pass never stalls. Reset clears control and the
// entry count only; slot contents are defined by the adds.
`timescale 1ns / 1ps
`default_nettype none
module periodic_event_timer_table_core #(
    parameter int TABLE_SLOTS = 32
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    pett_cmd_if.sink   cmd_ch,
    pett_res_if.source res_ch
);
    import pett_pkg::*;

    localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_SLOTS - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_SLOTS);

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    cmd_t              cmd_reg;
    logic [31:0]       now_reg, per_reg, by_reg, min_reg, min_next;
    logic [7:0]        hid_reg;
    status_t           rstat_reg, rstat_next;
    logic [4:0]        rslot_reg, rslot_next;
    logic [7:0]        rhid_reg, rhid_next;

    logic              ov_reg, ov_next;
    status_t           o_status_reg, o_status_next;
    logic [4:0]        o_slot_reg, o_slot_next;
    logic [7:0]        o_hid_reg, o_hid_next;
    logic [31:0]       o_due_reg, o_due_next;
    logic              o_last_reg, o_last_next;

    entry_t            chain_d [TABLE_SLOTS];
    entry_t            chain_q [TABLE_SLOTS];
    entry_t            head_q;
    logic              head_fire, head_keep, shift_en, room, out_free, accept;
    logic [31:0]       idx_wide, cnt_wide, next_due;

    assign room     = count_reg < CNT_FULL;
    assign out_free = !ov_reg || res_ch.ready;
    assign accept   = cmd_ch.valid && cmd_ch.ready;
    assign next_due = (count_reg == '0) ? sat_add(now_reg, 32'd1) : min_reg;
    assign idx_wide = 32'(idx_reg);
    assign cnt_wide = 32'(count_reg);

    // chain of slot cells, head feeds the tail
    for (genvar k = 0; k < TABLE_SLOTS; k++)
    begin : g_cell
        if (k == TABLE_SLOTS - 1)
        begin : g_tail
            assign chain_d[k] = head_q;
        end
        else
        begin : g_mid
            assign chain_d[k] = chain_q[k+1];
        end
        pett_cell u_cell (
            .clk      (clk),
            .shift_en (shift_en),
            .d        (chain_d[k]),
            .q        (chain_q[k])
        );
    end

    pett_head #(.IDX_W(IDX_W), .CNT_W(CNT_W)) u_head (
        .scan  (state_reg == S_SCAN),
        .cmd   (cmd_reg),
        .now   (now_reg),
        .per   (per_reg),
        .hid   (hid_reg),
        .by    (by_reg),
        .room  (room),
        .idx   (idx_reg),
        .count (count_reg),
        .d     (chain_q[0]),
        .q     (head_q),
        .fire  (head_fire),
        .keep  (head_keep)
    );

    // control: next state, counters and result register
    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        count_next    = count_reg;
        rem_next      = rem_reg;
        min_next      = min_reg;
        rstat_next    = rstat_reg;
        rslot_next    = rslot_reg;
        rhid_next     = rhid_reg;
        shift_en      = 1'b0;
        ov_next       = ov_reg && !res_ch.ready;
        o_status_next = o_status_reg;
        o_slot_next   = o_slot_reg;
        o_hid_next    = o_hid_reg;
        o_due_next    = o_due_reg;
        o_last_next   = o_last_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (cmd_t'(cmd_ch.command) != CMD_NOP))
                begin
                    state_next = S_SCAN;
                    idx_next   = '0;
                    rem_next   = '0;
                    min_next   = TIME_MAX;
                end
            end
            S_SCAN:
            begin
                shift_en = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (head_keep && (head_q.due < min_next))
                begin
                    min_next = head_q.due;
                end
                if (head_fire)
                begin
                    rem_next = rem_reg + 1'b1;
                end
                if (idx_reg == IDX_LAST)
                begin
                    idx_next   = '0;
                    state_next = S_SINGLE;
                    rslot_next = '0;
                    rhid_next  = '0;
                    case (cmd_reg)
                        CMD_ADD:
                        begin
                            if (room)
                            begin
                                rstat_next = ST_ADDED;
                                rslot_next = cnt_wide[4:0];
                                rhid_next  = hid_reg;
                                count_next = count_reg + 1'b1;
                            end
                            else
                            begin
                                rstat_next = ST_FULL;
                            end
                        end
                        CMD_RUN:
                        begin
                            rstat_next = ST_NONE;
                            if (rem_next != '0)
                            begin
                                state_next = S_EMIT;
                            end
                        end
                        default:
                        begin
                            rstat_next = ST_SETBACK;
                        end
                    endcase
                end
            end
            S_EMIT:
            begin
                if (!chain_q[0].fired || out_free)
                begin
                    shift_en = 1'b1;
                    idx_next = idx_reg + 1'b1;
                    if (chain_q[0].fired)
                    begin
                        ov_next       = 1'b1;
                        o_status_next = ST_FIRED;
                        o_slot_next   = idx_wide[4:0];
                        o_hid_next    = chain_q[0].hid;
                        o_due_next    = next_due;
                        o_last_next   = (rem_reg == CNT_W'(1));
                        rem_next      = rem_reg - 1'b1;
                    end
                    if (idx_reg == IDX_LAST)
                    begin
                        idx_next   = '0;
                        state_next = S_IDLE;
                    end
                end
            end
            S_SINGLE:
            begin
                if (out_free)
                begin
                    ov_next       = 1'b1;
                    o_status_next = rstat_reg;
                    o_slot_next   = rslot_reg;
                    o_hid_next    = rhid_reg;
                    o_due_next    = next_due;
                    o_last_next   = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            count_reg <= '0;
            rem_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            count_reg <= count_next;
            rem_reg   <= rem_next;
            ov_reg    <= ov_next;
        end
    end

    // capture command payload and result fields
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_t'(cmd_ch.command);
            now_reg <= cmd_ch.time_now;
            per_reg <= cmd_ch.period;
            hid_reg <= cmd_ch.handler_id;
            by_reg  <= cmd_ch.shift_by;
        end
        min_reg      <= min_next;
        rstat_reg    <= rstat_next;
        rslot_reg    <= rslot_next;
        rhid_reg     <= rhid_next;
        o_status_reg <= o_status_next;
        o_slot_reg   <= o_slot_next;
        o_hid_reg    <= o_hid_next;
        o_due_reg    <= o_due_next;
        o_last_reg   <= o_last_next;
    end

    assign cmd_ch.ready         = (state_reg == S_IDLE);
    assign res_ch.valid         = ov_reg;
    assign res_ch.status        = o_status_reg;
    assign res_ch.slot          = o_slot_reg;
    assign res_ch.fired_handler = o_hid_reg;
    assign res_ch.next_due      = o_due_reg;
    assign res_ch.last          = o_last_reg;

    // entry count never passes the table size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("entry count above table size");

    // every fired entry met in the delivery pass is still counted
    a_emit_rem: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_EMIT) && chain_q[0].fired) |-> (rem_reg != '0))
        else $error("fired entry with nothing left to deliver");

    // a real command always starts a scan
    a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd_ch.command != CMD_NOP)) |=> (state_reg == S_SCAN))
        else $error("accepted command did not start a scan");

endmodule
`default_nettype wire
